@@ rtl/utf8_byte_stream_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// short property wrappers shared by the decoder rtl, clocked on aclk and
// switched off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define U8D_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("u8d same-cycle check failed");

// next-cycle implication
`define U8D_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("u8d next-cycle check failed");

`endif

@@ rtl/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// types, constants and the lead byte helper of the utf8 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

    localparam int unsigned CODE_W   = 32;
    localparam int unsigned LEN_W    = 4;
    localparam int unsigned REM_W    = 3;
    localparam int unsigned CONT_BITS = 6;
    localparam logic [7:0]  CONT_MASK = 8'h3f;
    localparam logic [7:0]  FULL_MASK = 8'hff;

    // decoder state between bytes
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [CODE_W-1:0] acc;
        logic [LEN_W-1:0]  len;
    } u8d_state_t;

    // one result of a step
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              trunc;
    } u8d_result_t;

    // count of leading ones, 0 to 8
    function automatic logic [LEN_W-1:0] lead_ones(input logic [7:0] b);
        logic [LEN_W-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            run = run & b[i];
            if (run) begin
                n = n + LEN_W'(1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/u8d_step.sv @@
// ----------------------------------------------------------------------------
// u8d_step
// next state and result for one byte of the stream
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_step (
    input  wire logic [7:0]          data_byte,
    input  wire logic                buffer_end,
    input  wire u8d_pkg::u8d_state_t st,
    output u8d_pkg::u8d_state_t      st_next,
    output u8d_pkg::u8d_result_t     res
);
    import u8d_pkg::*;

    logic [LEN_W-1:0]  n;
    logic [7:0]        kept;
    logic [CODE_W-1:0] acc_sh;
    logic [REM_W-1:0]  rem_dec;

    assign n       = lead_ones(data_byte);
    assign kept    = (FULL_MASK >> n) & data_byte;
    assign acc_sh  = {st.acc[CODE_W-1-CONT_BITS:0], 6'(data_byte & CONT_MASK)};
    assign rem_dec = st.rem - REM_W'(1);

    always_comb begin
        st_next = st;
        res     = '0;
        if (st.rem == '0) begin
            if (n <= LEN_W'(1)) begin
                // ascii or lone continuation byte
                res = '{valid: 1'b1, code: CODE_W'(kept), len: LEN_W'(1), trunc: 1'b0};
            end else if (buffer_end) begin
                st_next = '0;
                res     = '{valid: 1'b1, code: '0, len: n, trunc: 1'b1};
            end else begin
                st_next = '{rem: REM_W'(n - LEN_W'(1)), acc: CODE_W'(kept), len: n};
            end
        end else begin
            if (rem_dec == '0) begin
                st_next = '0;
                res     = '{valid: 1'b1, code: acc_sh, len: st.len, trunc: 1'b0};
            end else if (buffer_end) begin
                st_next = '0;
                res     = '{valid: 1'b1, code: '0, len: st.len, trunc: 1'b1};
            end else begin
                st_next = '{rem: rem_dec, acc: acc_sh, len: st.len};
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/utf8_byte_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// streaming utf-8 byte to code point decoder
// ----------------------------------------------------------------------------
// Takes one byte per transaction and sustains one byte per clock while
// m_tready does not stall the output. A byte passes an input register,
// the combinational decode logic and a result register. A result is
// offered on m_tvalid once its final byte has moved from the input
// register into the result register. The next byte may follow in every
// cycle unless the output stalls; the only loop is the update of the
// sequence state. The lead byte's count of leading ones sets the sequence
// length (ascii and lone 10xxxxxx bytes count as one byte). Continuation
// bytes are not checked for their marker bits and the value wraps at 32
// bits. If s_tlast ends the buffer inside a sequence, one result with
// m_tuser set, code point zero and the announced length is given and the
// decoder returns to idle. Bytes that only extend a sequence give no result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_byte_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // buffer_end
    // decoded characters
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] code_point, [35:32] seq_length, rest zero
    output logic             m_tuser    // truncated
);
    import u8d_pkg::*;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // sequence state
    u8d_state_t  st_reg, st_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_trunc_reg;

    u8d_result_t res;
    logic        advance;
    logic        s_take;

    // the held byte moves on when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    u8d_step u_step (
        .data_byte  (in_byte_reg),
        .buffer_end (in_last_reg),
        .st         (st_reg),
        .st_next    (st_next),
        .res        (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && res.valid) begin
            out_code_reg  <= res.code;
            out_len_reg   <= res.len;
            out_trunc_reg <= res.trunc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_len_reg, out_code_reg};
    assign m_tuser  = out_trunc_reg;

`include "utf8_byte_stream_decoder_assert.svh"

    // a truncation result never carries a code point
    `U8D_ASSERT_NOW(a_trunc_code_zero, m_tvalid && m_tuser, m_tdata[31:0] == '0)
    // a truncation only happens inside a multi-byte sequence
    `U8D_ASSERT_NOW(a_trunc_len_multi, m_tvalid && m_tuser, m_tdata[35:32] >= 4'd2)
    // one-byte characters fit in seven bits
    `U8D_ASSERT_NOW(a_single_ascii, m_tvalid && (m_tdata[35:32] == 4'd1), m_tdata[31:7] == '0)
    // a byte that completes a sequence takes the decoder back to idle
    `U8D_ASSERT_NEXT(a_done_idle, advance && res.valid, st_reg.rem == '0)

endmodule

`default_nettype wire
